### sv/sglc_pkg.sv
package sglc_pkg;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] counter;
    } t_in_word;

    typedef struct packed {
        logic [30:0] drop_gap;
        logic [31:0] drop_total;
        logic [31:0] delivered_count;
        logic [15:0] drop_rate;
    } t_out_word;

    localparam logic OP_PACKET   = 1'b0;
    localparam logic OP_DELIVERY = 1'b1;

    localparam int GAP_BITS  = 31;
    localparam int DEN_BITS  = 33;
    localparam int RATE_BITS = 16;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_GAP_WAIT   = 5'b00010,
        S_RATE_START = 5'b00100,
        S_RATE_WAIT  = 5'b01000,
        S_DONE       = 5'b10000
    } t_state;

endpackage

### sv/sglc_div.sv
module sglc_div #(
    parameter int NUM_BITS = 48,
    parameter int DEN_W    = 33,
    parameter int STEP_W   = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [STEP_W-1:0]   i_steps,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [NUM_BITS-1:0] r_num;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;

    logic [DEN_W:0]      trial;
    logic [DEN_W+1:0]    diff;
    logic                take;

    // restoring step: quotient bits shift in behind the numerator
    always_comb begin
        trial = {r_rem, r_num[NUM_BITS-1]};
        diff  = {1'b0, trial} - {2'b00, r_den};
        take  = ~diff[DEN_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_BITS-2:0], take};
            r_rem <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

### sv/sequence_gap_loss_counter.sv
// Sequence gap loss counter.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
// packet event: opcode packet carries the sender counter, opcode delivery
// bumps the delivered total. Every input word yields one output word on
// o_out_valid / i_out_ready / o_out_data with the gap, both totals and the
// drop rate in fixed point with RATE_FRACTION_BITS fraction bits, low 16
// bits kept.
// One shared restoring divider, one quotient bit per cycle, does all work.
// When a known step forces the 31-bit gap division, it runs before the
// rate division. One word is in flight at a time; a new word is taken
// once the previous one is in the output register.
// The output register holds its word while i_out_ready is low; a finished
// word then waits inside and o_in_ready stays low until the register frees.
// Synchronous reset clears both totals, the stored counter and the learned
// step, and empties the output register.
module sequence_gap_loss_counter #(
    parameter int RATE_FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sglc_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sglc_pkg::t_out_word o_out_data
);

    import sglc_pkg::*;

    localparam int NUM_BITS = 32 + RATE_FRACTION_BITS;
    localparam int STEP_W   = $clog2(NUM_BITS + 1);
    localparam int GAP_PAD  = NUM_BITS - GAP_BITS;

    t_state              r_state, n_state;
    logic                r_have_last;
    logic [30:0]         r_last;
    logic [30:0]         r_step;
    logic [31:0]         r_dropped;
    logic [31:0]         r_delivered;
    logic [30:0]         r_gap;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                accept;
    logic                out_free;
    logic [31:0]         delta;
    logic                delta_pos;
    logic [30:0]         gap_q;
    logic [30:0]         gap_val;

    logic                div_start;
    logic [STEP_W-1:0]   div_steps;
    logic [NUM_BITS-1:0] div_num;
    logic [DEN_BITS-1:0] div_den;
    logic                div_done;
    logic [NUM_BITS-1:0] div_quot;

    sglc_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_W    (DEN_BITS),
        .STEP_W   (STEP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_steps (div_steps),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        delta     = {1'b0, i_in_data.counter[30:0]} - {1'b0, r_last};
        delta_pos = !delta[31] && (delta != 32'd0);
        gap_q     = div_quot[GAP_BITS-1:0];
        gap_val   = (gap_q != '0) ? gap_q - 31'd1 : '0;
    end

    // divider issue: gap division straight from acceptance, rate afterwards
    always_comb begin
        div_start = 1'b0;
        div_steps = STEP_W'(NUM_BITS);
        div_num   = {r_dropped, RATE_FRACTION_BITS'(0)};
        div_den   = {1'b0, r_dropped} + {1'b0, r_delivered} + DEN_BITS'(1);
        if (r_state == S_RATE_START) begin
            div_start = 1'b1;
        end else if (accept && i_in_data.opcode == OP_PACKET &&
                     !i_in_data.counter[31] && r_have_last && delta_pos &&
                     r_step != '0) begin
            div_start = 1'b1;
            div_steps = STEP_W'(GAP_BITS);
            div_num   = {delta[30:0], GAP_PAD'(0)};
            div_den   = {2'b00, r_step};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = div_start ? S_GAP_WAIT : S_RATE_START;
                end
            end
            S_GAP_WAIT: begin
                if (div_done) begin
                    n_state = S_RATE_START;
                end
            end
            S_RATE_START: begin
                n_state = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_last <= 1'b0;
            r_last      <= '0;
            r_step      <= '0;
            r_dropped   <= '0;
            r_delivered <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (i_in_data.opcode == OP_DELIVERY) begin
                    r_delivered <= r_delivered + 32'd1;
                end else if (!i_in_data.counter[31]) begin
                    r_have_last <= 1'b1;
                    r_last      <= i_in_data.counter[30:0];
                    if (r_have_last) begin
                        if (!delta_pos) begin
                            r_step <= '0;
                        end else if (r_step == '0) begin
                            r_step <= delta[30:0];
                        end
                    end
                end
            end
            if (r_state == S_GAP_WAIT && div_done) begin
                r_dropped <= r_dropped + {1'b0, gap_val};
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // quotient stays in the divider until the next word starts it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gap <= '0;
        end else if (r_state == S_GAP_WAIT && div_done) begin
            r_gap <= gap_val;
        end
        if (r_state == S_DONE && out_free) begin
            r_out.drop_gap        <= r_gap;
            r_out.drop_total      <= r_dropped;
            r_out.delivered_count <= r_delivered;
            r_out.drop_rate       <= div_quot[RATE_BITS-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready
    ) else $error("input taken while a word is in flight");

    a_div_done_expected: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_GAP_WAIT || r_state == S_RATE_WAIT)
    ) else $error("divider finished outside a wait state");

    a_result_loaded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && o_in_ready)
    ) else $error("finished word not presented");

endmodule

### test/tb_sequence_gap_loss_counter.sv
module tb_sequence_gap_loss_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import sglc_pkg::*;

    localparam int          RATE_FRAC  = 16;
    localparam logic [31:0] NO_COUNTER = 32'hFFFF_FFFF;
    localparam logic [31:0] CNT_MAX    = 32'h7FFF_FFFF;
    localparam int          TAIL_WAIT  = 2 * (RATE_FRAC + 68);

    class drop_scoreboard;
        bit          have_last;
        logic [31:0] last_cnt;
        logic [31:0] step;
        logic [31:0] drop_sum;
        logic [31:0] deliv_sum;
        t_out_word   pending_q[$];
        int          n_errors;
        int          n_checked;
        int          n_packets;
        int          n_deliveries;
        int          n_learned;
        int          n_forgotten;
        int          n_gaps;

        function new();
            have_last    = 1'b0;
            last_cnt     = NO_COUNTER;
            step         = '0;
            drop_sum     = '0;
            deliv_sum    = '0;
            n_errors     = 0;
            n_checked    = 0;
            n_packets    = 0;
            n_deliveries = 0;
            n_learned    = 0;
            n_forgotten  = 0;
            n_gaps       = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // work out the result of one accepted word and queue it
        function void note_input(t_in_word w);
            t_out_word   e;
            logic [31:0] gap;
            logic [31:0] q;
            longint      delta;
            bit [63:0]   num;
            bit [63:0]   den;
            gap = '0;
            if (w.opcode == OP_DELIVERY) begin
                deliv_sum = deliv_sum + 32'd1;
                n_deliveries++;
            end else begin
                n_packets++;
                if (!w.counter[31]) begin
                    if (have_last) begin
                        delta = longint'(w.counter) - longint'({32'b0, last_cnt});
                        if (delta > 0) begin
                            if (step == '0) begin
                                step = delta[31:0];
                                n_learned++;
                            end else begin
                                q   = 32'(delta / longint'({32'b0, step}));
                                gap = (q > 0) ? q - 32'd1 : 32'd0;
                                drop_sum = drop_sum + gap;
                                if (gap != 0) n_gaps++;
                            end
                        end else begin
                            step = '0;
                            n_forgotten++;
                        end
                    end
                    last_cnt  = w.counter;
                    have_last = 1'b1;
                end
            end
            den = {32'b0, drop_sum} + {32'b0, deliv_sum} + 64'd1;
            num = {32'b0, drop_sum} << RATE_FRAC;
            e.drop_gap        = gap[30:0];
            e.drop_total      = drop_sum;
            e.delivered_count = deliv_sum;
            e.drop_rate       = 16'(num / den);
            pending_q.push_back(e);
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            if (n_errors <= 30) $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("output word with nothing pending, total %0d",
                                          got.drop_total));
            end else begin
                want = pending_q.pop_front();
                if (got.drop_gap !== want.drop_gap)
                    report_mismatch($sformatf("word %0d drop_gap got %0d want %0d",
                                              n_checked, got.drop_gap, want.drop_gap));
                if (got.drop_total !== want.drop_total)
                    report_mismatch($sformatf("word %0d drop_total got %0d want %0d",
                                              n_checked, got.drop_total, want.drop_total));
                if (got.delivered_count !== want.delivered_count)
                    report_mismatch($sformatf("word %0d delivered_count got %0d want %0d",
                                              n_checked, got.delivered_count,
                                              want.delivered_count));
                if (got.drop_rate !== want.drop_rate)
                    report_mismatch($sformatf("word %0d drop_rate got %0d want %0d",
                                              n_checked, got.drop_rate, want.drop_rate));
            end
            n_checked++;
        endtask
    endclass

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;

    bit             no_idle = 1'b0;
    drop_scoreboard sb;

    always #2 i_clk = ~i_clk;

    sequence_gap_loss_counter #(
        .RATE_FRACTION_BITS(RATE_FRAC)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_word(input logic op, input logic [31:0] cnt);
        t_in_word w;
        int       idle;
        idle      = idle_len();
        w.opcode  = op;
        w.counter = cnt;
        repeat (idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_word(OP_DELIVERY, $urandom());
        send_word(OP_PACKET, NO_COUNTER);
        send_word(OP_PACKET, 32'h8000_0000);
        // three widest gaps in a row: the dropped total wraps
        repeat (3) begin
            send_word(OP_PACKET, 32'd0);
            send_word(OP_PACKET, 32'd1);
            send_word(OP_PACKET, CNT_MAX);
        end
        send_word(OP_DELIVERY, CNT_MAX);
        send_word(OP_DELIVERY, 32'h0000_0000);
        send_word(OP_PACKET, 32'd10);
        send_word(OP_PACKET, 32'd20);
        send_word(OP_PACKET, 32'd30);
        send_word(OP_PACKET, 32'd65);
        send_word(OP_PACKET, 32'd70);
        send_word(OP_PACKET, 32'd70);
        send_word(OP_PACKET, 32'd75);
        send_word(OP_PACKET, 32'hFFFF_FFFB);
        send_word(OP_DELIVERY, NO_COUNTER);
        send_word(OP_PACKET, 32'd90);
    endtask

    // mostly well-formed counter runs with random drops, plus noise
    task automatic run_random(input int n_words);
        longint      cur;
        longint      nxt;
        int unsigned stride;
        int          r;
        int          drops;
        cur    = 0;
        stride = 1;
        for (int i = 0; i < n_words; i++) begin
            no_idle = ((i % 400) >= 300) && ((i % 400) < 340);
            if (i == 550 || i == 1100) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 25) begin
                send_word(OP_DELIVERY, $urandom());
            end else if (r < 78) begin
                drops = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
                if (stride > 1 && $urandom_range(0, 19) == 0)
                    nxt = cur + $urandom_range(1, stride - 1);
                else
                    nxt = cur + longint'(stride) * (drops + 1);
                if (nxt > longint'({32'b0, CNT_MAX})) nxt = $urandom_range(0, 1000);
                cur = nxt;
                send_word(OP_PACKET, 32'(cur));
            end else if (r < 84) begin
                send_word(OP_PACKET, NO_COUNTER);
            end else if (r < 88) begin
                send_word(OP_PACKET, {1'b1, 31'($urandom())});
            end else if (r < 92) begin
                cur = cur - longint'($urandom_range(0, stride));
                if (cur < 0) cur = 0;
                send_word(OP_PACKET, 32'(cur));
            end else if (r < 95) begin
                cur = $urandom_range(0, CNT_MAX);
                send_word(OP_PACKET, 32'(cur));
            end else begin
                r = $urandom_range(0, 19);
                if (r < 14) stride = $urandom_range(1, 16);
                else if (r < 19) stride = $urandom_range(17, 1000);
                else stride = $urandom_range(1001, 1 << 24);
                if ($urandom_range(0, 9) == 0) cur = $urandom_range(0, CNT_MAX);
                else cur = $urandom_range(0, 5000);
                send_word(OP_PACKET, 32'(cur));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : rx
        int stall_left;
        int n;
        stall_left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (out_valid && out_ready) begin
                sb.check_result(out_data);
                // long hold-off so the block backs up onto its input
                if (sb.n_checked == 300 || sb.n_checked == 1000) stall_left = 500;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                n = idle_len();
                if (n == 0) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready  <= 1'b0;
                    stall_left = n - 1;
                end
            end
        end
    end

    initial begin
        #6ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_drained();
        run_random(1626);
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("covered %0d packet words and %0d delivery words, %0d results checked",
                 sb.n_packets, sb.n_deliveries, sb.n_checked);
        $display("steps learned %0d, forgotten %0d, nonzero gaps %0d, final drop total %0d",
                 sb.n_learned, sb.n_forgotten, sb.n_gaps, sb.drop_sum);
        if (sb.n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
